FILE: hdl/dah_pkg.sv
// ----------------------------------------------------------------------------
// dah_pkg
// Shared types, codes and widths of the dijet asymmetry histogrammer.
// ----------------------------------------------------------------------------
package dah_pkg;

    localparam int OP_W      = 2;
    localparam int EVENT_W   = 32;
    localparam int ENERGY_W  = 16;
    localparam int ANGLE_W   = 16;
    localparam int DIFF_W    = 17;
    localparam int BIN_W     = 6;
    localparam int COUNT_W   = 32;
    localparam int THR_W     = 16;
    localparam int FRAC_W    = 9;
    localparam int ATHR_W    = 15;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [OP_W-1:0] OP_JET   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_THR  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_THR   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_THR = 8'd3;

    localparam logic [THR_W-1:0]  LEAD_THR_RST  = 16'd160;
    localparam logic [THR_W-1:0]  SUB_THR_RST   = 16'd40;
    localparam logic [FRAC_W-1:0] MATCH_RST     = 9'd205;
    localparam logic [ATHR_W-1:0] ANGLE_THR_RST = 15'd6431;

    typedef struct packed {
        logic load_item;
        logic res_clear;
        logic update_jet;
        logic seed;
        logic close_clear;
        logic div_start;
        logic div_sel;
        logic capture_t;
        logic capture_r;
        logic hist_rd;
        logic hist_wr;
        logic read_rd;
        logic read_capture;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            active;
        logic            same_event;
        logic            div_done;
    } sts_t;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [ANGLE_W-1:0] a,
                                                   input logic signed [ANGLE_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = {a[ANGLE_W-1], a} - {b[ANGLE_W-1], b};
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

endpackage

FILE: hdl/dah_if.sv
// ----------------------------------------------------------------------------
// dah channel interfaces
// Jet item, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface dah_item_if;
    logic                                      valid;
    logic                                      ready;
    logic [dah_pkg::OP_W-1:0]                  operation;
    logic [dah_pkg::EVENT_W-1:0]               event_number;
    logic [dah_pkg::ENERGY_W-1:0]              truth_energy;
    logic [dah_pkg::ENERGY_W-1:0]              reco_energy;
    logic signed [dah_pkg::ANGLE_W-1:0]        truth_angle;
    logic signed [dah_pkg::ANGLE_W-1:0]        reco_angle;
    logic [dah_pkg::BIN_W-1:0]                 bin_index;

    modport source (output valid, operation, event_number, truth_energy, reco_energy,
                    truth_angle, reco_angle, bin_index, input ready);
    modport sink (input valid, operation, event_number, truth_energy, reco_energy,
                  truth_angle, reco_angle, bin_index, output ready);
endinterface

interface dah_result_if;
    logic                          valid;
    logic                          ready;
    logic                          event_closed;
    logic                          truth_filled;
    logic [dah_pkg::BIN_W-1:0]     truth_bin;
    logic                          reco_filled;
    logic [dah_pkg::BIN_W-1:0]     reco_bin;
    logic [dah_pkg::COUNT_W-1:0]   truth_count;
    logic [dah_pkg::COUNT_W-1:0]   reco_count;

    modport source (output valid, event_closed, truth_filled, truth_bin, reco_filled,
                    reco_bin, truth_count, reco_count, input ready);
    modport sink (input valid, event_closed, truth_filled, truth_bin, reco_filled,
                  reco_bin, truth_count, reco_count, output ready);
endinterface

interface dah_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dah_pkg::CFG_IDX_W-1:0]   index;
    logic [dah_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/dijet_asymmetry_histogrammer_top.sv
// ----------------------------------------------------------------------------
// dijet_asymmetry_histogrammer_top
// Tracks leading and subleading jets per event and bins their asymmetry.
// ----------------------------------------------------------------------------
// One word is handled at a time. A jet inside the open event, a seeding jet or
// an idle flush goes from decode to the finish state, which loads the result
// register when no earlier result is still pending; a histogram read passes a
// read-wait state first. Closing an event runs the shared restoring divider
// twice, once for truth and once for reco, one quotient bit a cycle, then a
// read-modify-write of both histograms. Histogram counts start at zero from
// reset with no clearing pass. A finished result waits in its own register, so
// the next word can be taken meanwhile.
module dijet_asymmetry_histogrammer_top #(
    parameter int NUM_BINS    = 50,
    parameter int ENERGY_BITS = 16
) (
    input logic          clk,
    input logic          rst_n,
    dah_item_if.sink     item,
    dah_result_if.source result,
    dah_cfg_if.sink      cfg
);

    dah_pkg::cmd_t cmd;
    dah_pkg::sts_t sts;

    assign cfg.ready = 1'b1;

    dah_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    dah_datapath #(
        .NUM_BINS    (NUM_BINS),
        .ENERGY_BITS (ENERGY_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .operation    (item.operation),
        .event_number (item.event_number),
        .truth_energy (item.truth_energy),
        .reco_energy  (item.reco_energy),
        .truth_angle  (item.truth_angle),
        .reco_angle   (item.reco_angle),
        .bin_index    (item.bin_index),
        .event_closed (result.event_closed),
        .truth_filled (result.truth_filled),
        .truth_bin    (result.truth_bin),
        .reco_filled  (result.reco_filled),
        .reco_bin     (result.reco_bin),
        .truth_count  (result.truth_count),
        .reco_count   (result.reco_count)
    );

endmodule

FILE: hdl/dah_divider.sv
// ----------------------------------------------------------------------------
// dah_divider
// Restoring divider, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module dah_divider #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(shifted - {1'b0, den_reg}) : DEN_W'(shifted);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/dah_datapath.sv
// ----------------------------------------------------------------------------
// dah_datapath
// Jet tracking, configuration, binning divider, histograms and result words.
// ----------------------------------------------------------------------------
module dah_datapath #(
    parameter int NUM_BINS    = 50,
    parameter int ENERGY_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dah_pkg::cmd_t                     cmd,
    output dah_pkg::sts_t                     sts,
    input  logic                              cfg_we,
    input  logic [dah_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dah_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic [dah_pkg::OP_W-1:0]          operation,
    input  logic [dah_pkg::EVENT_W-1:0]       event_number,
    input  logic [dah_pkg::ENERGY_W-1:0]      truth_energy,
    input  logic [dah_pkg::ENERGY_W-1:0]      reco_energy,
    input  logic signed [dah_pkg::ANGLE_W-1:0] truth_angle,
    input  logic signed [dah_pkg::ANGLE_W-1:0] reco_angle,
    input  logic [dah_pkg::BIN_W-1:0]         bin_index,
    output logic                              event_closed,
    output logic                              truth_filled,
    output logic [dah_pkg::BIN_W-1:0]         truth_bin,
    output logic                              reco_filled,
    output logic [dah_pkg::BIN_W-1:0]         reco_bin,
    output logic [dah_pkg::COUNT_W-1:0]       truth_count,
    output logic [dah_pkg::COUNT_W-1:0]       reco_count
);

    localparam int EW    = ENERGY_BITS;
    localparam int AW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int NBW   = $clog2(NUM_BINS + 1);
    localparam int NUM_W = EW + NBW;
    localparam int DEN_W = EW + 1;
    localparam int MW    = EW + 9;
    localparam int IXW   = 10;
    localparam int CW    = dah_pkg::COUNT_W;

    // configuration
    logic [dah_pkg::THR_W-1:0]  lead_thr_reg;
    logic [dah_pkg::THR_W-1:0]  sub_thr_reg;
    logic [dah_pkg::FRAC_W-1:0] match_reg;
    logic [dah_pkg::ATHR_W-1:0] angle_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_thr_reg  <= dah_pkg::LEAD_THR_RST;
            sub_thr_reg   <= dah_pkg::SUB_THR_RST;
            match_reg     <= dah_pkg::MATCH_RST;
            angle_thr_reg <= dah_pkg::ANGLE_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dah_pkg::CFG_LEAD_THR:  lead_thr_reg  <= cfg_data;
                dah_pkg::CFG_SUB_THR:   sub_thr_reg   <= cfg_data;
                dah_pkg::CFG_MATCH:     match_reg     <= cfg_data[dah_pkg::FRAC_W-1:0];
                dah_pkg::CFG_ANGLE_THR: angle_thr_reg <= cfg_data[dah_pkg::ATHR_W-1:0];
                default: ;
            endcase
        end
    end

    // latched item
    logic [dah_pkg::OP_W-1:0]           op_reg;
    logic [dah_pkg::EVENT_W-1:0]        ev_reg;
    logic [EW-1:0]                      te_reg;
    logic [EW-1:0]                      re_reg;
    logic signed [dah_pkg::ANGLE_W-1:0] ta_reg;
    logic signed [dah_pkg::ANGLE_W-1:0] ra_reg;
    logic [dah_pkg::BIN_W-1:0]          idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg  <= operation;
            ev_reg  <= event_number;
            te_reg  <= EW'(truth_energy);
            re_reg  <= EW'(reco_energy);
            ta_reg  <= truth_angle;
            ra_reg  <= reco_angle;
            idx_reg <= bin_index;
        end
    end

    // open event state
    logic                               active_reg;
    logic [dah_pkg::EVENT_W-1:0]        open_event_reg;
    logic [EW-1:0]                      lt_reg, st_reg, lr_reg, sr_reg;
    logic signed [dah_pkg::ANGLE_W-1:0] lat_reg, lar_reg, sat_reg, sar_reg;
    logic [dah_pkg::DIFF_W-1:0]         dt_reg, dr_reg;

    logic [MW-1:0] match_lhs, match_rhs;
    logic          match, lead_win, sub_win;

    assign match_lhs = MW'({re_reg, 8'h00});
    assign match_rhs = MW'(match_reg) * MW'(te_reg);
    assign match     = match_lhs > match_rhs;
    assign lead_win  = match && (te_reg > lt_reg) && (MW'(te_reg) > MW'(lead_thr_reg));
    assign sub_win   = match && (te_reg > st_reg) && (MW'(te_reg) > MW'(sub_thr_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            open_event_reg <= '0;
            lt_reg  <= '0;
            st_reg  <= '0;
            lr_reg  <= '0;
            sr_reg  <= '0;
            lat_reg <= '0;
            lar_reg <= '0;
            sat_reg <= '0;
            sar_reg <= '0;
            dt_reg  <= '0;
            dr_reg  <= '0;
        end
        else if (cmd.seed)
        begin
            active_reg     <= 1'b1;
            open_event_reg <= ev_reg;
            lt_reg  <= te_reg;
            lr_reg  <= re_reg;
            lat_reg <= ta_reg;
            lar_reg <= ra_reg;
            st_reg  <= '0;
            sr_reg  <= '0;
            sat_reg <= '0;
            sar_reg <= '0;
            dt_reg  <= '0;
            dr_reg  <= '0;
        end
        else if (cmd.close_clear)
        begin
            active_reg <= 1'b0;
        end
        else if (cmd.update_jet)
        begin
            if (lead_win)
            begin
                // old leader drops to subleader
                st_reg  <= lt_reg;
                sr_reg  <= lr_reg;
                sat_reg <= lat_reg;
                sar_reg <= lar_reg;
                lt_reg  <= te_reg;
                lr_reg  <= re_reg;
                lat_reg <= ta_reg;
                lar_reg <= ra_reg;
                dt_reg  <= dah_pkg::abs_diff(ta_reg, lat_reg);
                dr_reg  <= dah_pkg::abs_diff(ra_reg, lar_reg);
            end
            else if (sub_win)
            begin
                st_reg  <= te_reg;
                sr_reg  <= re_reg;
                sat_reg <= ta_reg;
                sar_reg <= ra_reg;
                dt_reg  <= dah_pkg::abs_diff(lat_reg, ta_reg);
                dr_reg  <= dah_pkg::abs_diff(lar_reg, ra_reg);
            end
        end
    end

    // binning
    logic [EW-1:0]    e1, e2;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic             ok_t, ok_r;

    assign e1      = cmd.div_sel ? lr_reg : lt_reg;
    assign e2      = cmd.div_sel ? sr_reg : st_reg;
    assign div_num = NUM_W'(NUM_BINS) * NUM_W'(e1 - e2);
    assign div_den = DEN_W'(e1) + DEN_W'(e2);
    assign ok_t    = (dt_reg > dah_pkg::DIFF_W'(angle_thr_reg)) && (st_reg != '0)
                     && (lt_reg >= st_reg);
    assign ok_r    = (dr_reg > dah_pkg::DIFF_W'(angle_thr_reg)) && (sr_reg != '0)
                     && (lr_reg >= sr_reg);

    dah_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    logic [AW-1:0] bin_t_reg, bin_r_reg;
    logic          fill_t_reg, fill_r_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture_t)
        begin
            bin_t_reg  <= div_quo[AW-1:0];
            fill_t_reg <= ok_t;
        end
        if (cmd.capture_r)
        begin
            bin_r_reg  <= div_quo[AW-1:0];
            fill_r_reg <= ok_r;
        end
    end

    // histograms, entries not yet written read as zero
    logic [CW-1:0]       hist_t_mem [NUM_BINS];
    logic [CW-1:0]       hist_r_mem [NUM_BINS];
    logic [NUM_BINS-1:0] vld_t_reg, vld_r_reg;
    logic [CW-1:0]       rd_t_reg, rd_r_reg;
    logic                rv_t_reg, rv_r_reg;
    logic [AW-1:0]       addr_t, addr_r;
    logic [CW-1:0]       cur_t, cur_r, inc_t, inc_r;
    logic                idx_ok;

    assign idx_ok = IXW'(idx_reg) < IXW'(NUM_BINS);
    assign addr_t = cmd.read_rd ? AW'(idx_reg) : bin_t_reg;
    assign addr_r = cmd.read_rd ? AW'(idx_reg) : bin_r_reg;
    assign cur_t  = rv_t_reg ? rd_t_reg : '0;
    assign cur_r  = rv_r_reg ? rd_r_reg : '0;
    assign inc_t  = (cur_t == '1) ? cur_t : cur_t + 1'b1;
    assign inc_r  = (cur_r == '1) ? cur_r : cur_r + 1'b1;

    always_ff @(posedge clk)
    begin
        rd_t_reg <= hist_t_mem[addr_t];
        rd_r_reg <= hist_r_mem[addr_r];
        if (cmd.hist_wr && fill_t_reg)
            hist_t_mem[bin_t_reg] <= inc_t;
        if (cmd.hist_wr && fill_r_reg)
            hist_r_mem[bin_r_reg] <= inc_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_t_reg <= '0;
            vld_r_reg <= '0;
            rv_t_reg  <= 1'b0;
            rv_r_reg  <= 1'b0;
        end
        else
        begin
            rv_t_reg <= vld_t_reg[addr_t];
            rv_r_reg <= vld_r_reg[addr_r];
            if (cmd.hist_wr && fill_t_reg)
                vld_t_reg[bin_t_reg] <= 1'b1;
            if (cmd.hist_wr && fill_r_reg)
                vld_r_reg[bin_r_reg] <= 1'b1;
        end
    end

    // result word under construction, then the output word
    logic                       res_closed_reg, res_ft_reg, res_fr_reg;
    logic [dah_pkg::BIN_W-1:0]  res_bt_reg, res_br_reg;
    logic [CW-1:0]              res_ct_reg, res_cr_reg;
    logic                       out_closed_reg, out_ft_reg, out_fr_reg;
    logic [dah_pkg::BIN_W-1:0]  out_bt_reg, out_br_reg;
    logic [CW-1:0]              out_ct_reg, out_cr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.res_clear)
        begin
            res_closed_reg <= 1'b0;
            res_ft_reg     <= 1'b0;
            res_fr_reg     <= 1'b0;
            res_bt_reg     <= '0;
            res_br_reg     <= '0;
            res_ct_reg     <= '0;
            res_cr_reg     <= '0;
        end
        else if (cmd.hist_wr)
        begin
            res_closed_reg <= 1'b1;
            res_ft_reg     <= fill_t_reg;
            res_fr_reg     <= fill_r_reg;
            res_bt_reg     <= fill_t_reg ? dah_pkg::BIN_W'(bin_t_reg) : '0;
            res_br_reg     <= fill_r_reg ? dah_pkg::BIN_W'(bin_r_reg) : '0;
        end
        else if (cmd.read_capture)
        begin
            res_ct_reg <= idx_ok ? cur_t : '0;
            res_cr_reg <= idx_ok ? cur_r : '0;
        end
        if (cmd.out_load)
        begin
            out_closed_reg <= res_closed_reg;
            out_ft_reg     <= res_ft_reg;
            out_fr_reg     <= res_fr_reg;
            out_bt_reg     <= res_bt_reg;
            out_br_reg     <= res_br_reg;
            out_ct_reg     <= res_ct_reg;
            out_cr_reg     <= res_cr_reg;
        end
    end

    assign event_closed = out_closed_reg;
    assign truth_filled = out_ft_reg;
    assign truth_bin    = out_bt_reg;
    assign reco_filled  = out_fr_reg;
    assign reco_bin     = out_br_reg;
    assign truth_count  = out_ct_reg;
    assign reco_count   = out_cr_reg;

    assign sts.op         = op_reg;
    assign sts.active     = active_reg;
    assign sts.same_event = ev_reg == open_event_reg;
    assign sts.div_done   = div_done;

endmodule

FILE: hdl/dah_ctrl.sv
// ----------------------------------------------------------------------------
// dah_ctrl
// Sequencer: decodes each word, steps the close of an event, loads results.
// ----------------------------------------------------------------------------
module dah_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output dah_pkg::cmd_t cmd,
    input  dah_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_DIV_T,
        S_DIV_R,
        S_HIST_RD,
        S_HIST_WR,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic   seed_after_reg, seed_after_next;
    logic   in_fire;

    assign in_ready  = state_reg == S_IDLE;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        seed_after_next = seed_after_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load_item = 1'b1;
                    cmd.res_clear = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.op)
                    dah_pkg::OP_JET:
                    begin
                        if (sts.active && sts.same_event)
                        begin
                            cmd.update_jet = 1'b1;
                            state_next     = S_FINISH;
                        end
                        else if (sts.active)
                        begin
                            // new event number closes the open one first
                            cmd.div_start   = 1'b1;
                            seed_after_next = 1'b1;
                            state_next      = S_DIV_T;
                        end
                        else
                        begin
                            cmd.seed   = 1'b1;
                            state_next = S_FINISH;
                        end
                    end
                    dah_pkg::OP_READ:
                    begin
                        cmd.read_rd = 1'b1;
                        state_next  = S_RD_WAIT;
                    end
                    dah_pkg::OP_FLUSH:
                    begin
                        if (sts.active)
                        begin
                            cmd.div_start   = 1'b1;
                            seed_after_next = 1'b0;
                            state_next      = S_DIV_T;
                        end
                        else
                            state_next = S_FINISH;
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_RD_WAIT:
            begin
                cmd.read_capture = 1'b1;
                state_next       = S_FINISH;
            end
            S_DIV_T:
            begin
                if (sts.div_done)
                begin
                    cmd.capture_t = 1'b1;
                    cmd.div_sel   = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_R;
                end
            end
            S_DIV_R:
            begin
                cmd.div_sel = 1'b1;
                if (sts.div_done)
                begin
                    cmd.capture_r = 1'b1;
                    state_next    = S_HIST_RD;
                end
            end
            S_HIST_RD:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = S_HIST_WR;
            end
            S_HIST_WR:
            begin
                cmd.hist_wr = 1'b1;
                if (seed_after_reg)
                    cmd.seed = 1'b1;
                else
                    cmd.close_clear = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            seed_after_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            seed_after_reg <= seed_after_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_DECODE)
        else $error("accepted word not decoded");

    a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result word overwritten while pending");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_DIV_T || state_reg == S_DIV_R))
        else $error("divider finished outside a wait state");

    a_close_ends_event: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HIST_WR && !seed_after_reg) |=> !sts.active)
        else $error("flush left the event open");

endmodule
